FILE: rtl/ftfd_pkg.sv
// Shared constants and types for the tail-delimited float frame deframer.
package ftfd_pkg;

  localparam int FRAME_BYTES_DEF = 128;
  localparam int MAX_VALUES_DEF  = 16;

  localparam logic [7:0] TAIL_B0 = 8'h00;
  localparam logic [7:0] TAIL_B1 = 8'h00;
  localparam logic [7:0] TAIL_B2 = 8'h80;
  localparam logic [7:0] TAIL_B3 = 8'h7F;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_OUT
  } ftfd_state_t;

endpackage

FILE: rtl/float_tail_frame_deframer_top.sv
// Top level of the tail-delimited float frame deframer.
//
// Bytes are taken one per cycle while no frame is being read out. When the last four bytes
// of a frame are 00 00 80 7F and the payload is a nonzero multiple of four bytes of at most
// MAX_VALUES words, each word is emitted little-endian, with last set on the final one; a bad
// frame or a byte arriving into a full buffer bumps dropped_count. Readout goes through the
// single read port of the frame buffer, one byte per cycle; each word is assembled in S_READ
// and then held in the output register in S_OUT while out_stall is high, and input is held
// off for the whole readout of a frame.
module float_tail_frame_deframer_top
  import ftfd_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int MAX_VALUES  = MAX_VALUES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] value_bits,
  output logic [3:0]  value_index,
  output logic        last,
  output logic [31:0] dropped_count
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int LW = $clog2(FRAME_BYTES + 1);
  localparam int KW = $clog2(MAX_VALUES + 1);

  ftfd_state_t state, state_next;

  logic [LW-1:0] len;
  logic [31:0]   drop;
  logic [23:0]   hist;
  logic [KW-1:0] word_k;
  logic [KW-1:0] word_last;
  logic [2:0]    phase;
  logic [31:0]   acc;

  logic          in_acc;
  logic          full;
  logic [LW-1:0] len_new;
  logic          tail_hit;
  logic [LW-1:0] payload;
  logic [LW-3:0] payload_words;
  logic          frame_ok;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [AW+KW+1:0] rd_addr_wide;
  logic [KW+3:0] index_wide;
  logic [7:0]    rd_data;

  assign in_acc = in_valid && !in_stall;
  assign full   = (len == LW'(FRAME_BYTES));

  // A full buffer restarts: the new byte goes to slot zero.
  assign wr_addr = full ? '0 : len[AW-1:0];
  assign len_new = full ? LW'(1) : len + LW'(1);

  assign tail_hit = (len_new >= LW'(4)) && (hist[23:16] == TAIL_B0) &&
                    (hist[15:8] == TAIL_B1) && (hist[7:0] == TAIL_B2) &&
                    (rx_byte == TAIL_B3);

  assign payload       = len_new - LW'(4);
  assign payload_words = payload[LW-1:2];
  assign frame_ok      = (payload != '0) && (payload[1:0] == 2'b00) &&
                         (32'(payload_words) <= 32'(MAX_VALUES));

  assign rd_addr_wide = {{AW{1'b0}}, word_k, phase[1:0]};
  assign rd_addr      = rd_addr_wide[AW-1:0];

  ftfd_buf #(
    .DEPTH (FRAME_BYTES)
  ) u_buf (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_addr),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && tail_hit && frame_ok) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (phase == 3'd4) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = (word_k == word_last) ? S_IDLE : S_READ;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      S_IDLE:  in_stall  = 1'b0;
      S_READ:  in_stall  = 1'b1;
      S_OUT:   out_valid = 1'b1;
      default: in_stall  = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
      drop  <= '0;
      phase <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        if (tail_hit) begin
          len <= '0;
          if (!frame_ok) begin
            drop <= drop + 32'd1;
          end
        end else begin
          len <= len_new;
          if (full) begin
            drop <= drop + 32'd1;
          end
        end
      end
      if (state == S_READ) begin
        phase <= (phase == 3'd4) ? 3'd0 : phase + 3'd1;
      end
    end
  end

  assign index_wide = {4'b0000, word_k};

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      hist <= {hist[15:0], rx_byte};
    end
    if (state == S_IDLE) begin
      word_k    <= '0;
      word_last <= KW'(payload_words - 1'b1);
    end else if (state == S_OUT && !out_stall) begin
      word_k <= word_k + KW'(1);
    end
    if (state == S_READ && phase != 3'd0) begin
      acc <= {rd_data, acc[31:8]};
    end
    if (state == S_READ && phase == 3'd4) begin
      value_bits  <= {rd_data, acc[31:8]};
      value_index <= index_wide[3:0];
      last        <= (word_k == word_last);
    end
  end

  assign dropped_count = drop;

  a_no_input_during_output: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a word is pending");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(FRAME_BYTES))
    else $error("frame length beyond buffer");

  a_drop_quiet_in_readout: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |=> $stable(drop))
    else $error("drop count moved during readout");

  a_readout_follows_phase: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ && phase == 3'd4) |=> (state == S_OUT))
    else $error("assembled word not presented");

endmodule

FILE: rtl/ftfd_buf.sv
// Frame byte buffer: one write port, one read port with registered read data.
module ftfd_buf #(
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [7:0]               rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: dv/float_tail_frame_deframer_top_tb.sv
// Self-checking testbench for the tail-delimited float frame deframer.
`timescale 1ns / 1ps

module float_tail_frame_deframer_top_tb;
  import ftfd_pkg::*;

  typedef struct packed {
    logic [31:0] bits;
    logic [3:0]  index;
    logic        last;
    logic [31:0] drops;
  } word_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] value_bits;
  logic [3:0]  value_index;
  logic        last;
  logic [31:0] dropped_count;

  // Deframer state as predicted
  logic [7:0]  frame_mem [FRAME_BYTES_DEF];
  int unsigned fill_count = 0;
  logic [31:0] drop_tally = '0;
  word_rec_t   word_q [$];

  int unsigned fail_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned frames_emitted = 0;
  bit          send_idle = 1'b0;
  bit          recv_idle = 1'b0;
  int unsigned hold_left = 0;

  float_tail_frame_deframer_top #(
    .FRAME_BYTES(FRAME_BYTES_DEF),
    .MAX_VALUES (MAX_VALUES_DEF)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .value_bits   (value_bits),
    .value_index  (value_index),
    .last         (last),
    .dropped_count(dropped_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void deframe_byte(input logic [7:0] b);
    int unsigned payload;
    int unsigned nwords;
    word_rec_t   rec;
    if (fill_count >= FRAME_BYTES_DEF) begin
      fill_count = 0;
      drop_tally = drop_tally + 32'd1;
    end
    frame_mem[fill_count] = b;
    fill_count++;
    if (fill_count < 4) return;
    if (frame_mem[fill_count-4] != TAIL_B0 || frame_mem[fill_count-3] != TAIL_B1 ||
        frame_mem[fill_count-2] != TAIL_B2 || frame_mem[fill_count-1] != TAIL_B3) return;
    payload = fill_count - 4;
    nwords  = payload / 4;
    fill_count = 0;
    if (payload == 0 || payload % 4 != 0 || nwords > MAX_VALUES_DEF) begin
      drop_tally = drop_tally + 32'd1;
      return;
    end
    for (int unsigned k = 0; k < nwords; k++) begin
      rec.bits  = {frame_mem[4*k+3], frame_mem[4*k+2], frame_mem[4*k+1], frame_mem[4*k]};
      rec.index = k[3:0];
      rec.last  = (k + 1 == nwords);
      rec.drops = drop_tally;
      word_q.push_back(rec);
    end
    frames_emitted++;
  endfunction

  // Check results first, then predict from the request taken at this edge
  always @(posedge clk) begin : monitor
    word_rec_t rec;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (word_q.size() == 0) begin
          $error("unexpected result: value_bits %h value_index %0d", value_bits, value_index);
          fail_count++;
        end else begin
          rec = word_q.pop_front();
          words_checked++;
          if (value_bits !== rec.bits) begin
            $error("value_bits: expected %h, actual %h", rec.bits, value_bits);
            fail_count++;
          end
          if (value_index !== rec.index) begin
            $error("value_index: expected %0d, actual %0d", rec.index, value_index);
            fail_count++;
          end
          if (last !== rec.last) begin
            $error("last: expected %b, actual %b", rec.last, last);
            fail_count++;
          end
          if (dropped_count !== rec.drops) begin
            $error("dropped_count: expected %0d, actual %0d", rec.drops, dropped_count);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) deframe_byte(rx_byte);
    end
  end

  // Receiver pacing: draw a hold-off after every accepted result
  always @(posedge clk) begin
    if (out_valid && !out_stall) hold_left = recv_idle ? $urandom_range(0, 18) : 0;
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
  endtask

  task automatic send_tail();
    send_byte(TAIL_B0);
    send_byte(TAIL_B1);
    send_byte(TAIL_B2);
    send_byte(TAIL_B3);
  endtask

  // Favor tail bytes so partial tails show up inside payloads
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return TAIL_B0;
      1: return TAIL_B2;
      2: return TAIL_B3;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_good_frames();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_word(32'h0000_0000);
    send_tail();
    send_word(32'hFFFF_FFFF);
    send_word(32'h3F80_0000);
    send_tail();
    send_idle = 1'b1;
    recv_idle = 1'b1;
    for (int i = 0; i < MAX_VALUES_DEF; i++) send_word($urandom ^ (32'h1 << i));
    send_tail();
  endtask

  task automatic test_bad_frames();
    send_idle = 1'b1;
    recv_idle = 1'b0;
    // empty payload
    send_tail();
    // payload of five bytes
    send_word(32'h1234_5678);
    send_byte(8'hAB);
    send_tail();
    // one word too many
    for (int i = 0; i <= MAX_VALUES_DEF; i++) send_word($urandom);
    send_tail();
    // a good frame afterwards carries the new drop count
    send_word(32'hC0DE_F00D);
    send_tail();
  endtask

  task automatic test_embedded_tail();
    send_idle = 1'b0;
    recv_idle = 1'b1;
    // tail right after one word ends the frame there
    send_word(32'h4433_2211);
    send_tail();
    // near-tails that must not end the frame
    send_word({TAIL_B3, TAIL_B2, TAIL_B1, 8'h01});
    send_word({8'h7E, TAIL_B2, TAIL_B1, TAIL_B0});
    send_tail();
    // tail at a misaligned offset drops the frame
    send_byte(8'h5A);
    send_byte(8'hA5);
    send_tail();
  endtask

  task automatic test_overflow();
    send_idle = 1'b0;
    recv_idle = 1'b0;
    // overfill by one; the extra byte starts a new frame
    for (int i = 0; i < FRAME_BYTES_DEF; i++) send_byte(8'hA5);
    send_byte(8'hEF);
    send_byte(8'hBE);
    send_byte(8'hAD);
    send_byte(8'hDE);
    send_tail();
  endtask

  task automatic test_random_stream();
    int unsigned start_bytes;
    int unsigned nwords;
    int unsigned njunk;
    start_bytes = bytes_sent;
    while (bytes_sent - start_bytes < 40) begin
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0: begin
          // junk then tail: usually a misaligned payload
          njunk = $urandom_range(0, 10);
          for (int i = 0; i < njunk; i++) send_byte(pick_byte());
          send_tail();
        end
        1: begin
          // junk with no tail corrupts the next frame
          njunk = $urandom_range(1, 8);
          for (int i = 0; i < njunk; i++) send_byte(pick_byte());
        end
        default: begin
          nwords = ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_VALUES_DEF + 1)
                                               : $urandom_range(1, 4);
          for (int i = 0; i < 4 * nwords; i++) send_byte(pick_byte());
          send_tail();
        end
      endcase
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_good_frames();
    test_bad_frames();
    test_embedded_tail();
    test_overflow();
    test_random_stream();
    in_valid <= 1'b0;
    drain_cycles = 0;
    do begin
      @(posedge clk);
      drain_cycles++;
    end while (word_q.size() > 0 && drain_cycles < 20000);
    repeat (150) @(posedge clk);
    if (word_q.size() > 0) begin
      $error("%0d expected words never arrived", word_q.size());
      fail_count++;
    end
    $display("Sent %0d bytes; %0d frames emitted, %0d words checked, %0d drops counted.",
             bytes_sent, frames_emitted, words_checked, drop_tally);
    if (fail_count == 0) begin
      $display("float_tail_frame_deframer_top_tb passed");
    end else begin
      $display("float_tail_frame_deframer_top_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("float_tail_frame_deframer_top_tb failed");
    $finish;
  end

endmodule

FILE: files.f
rtl/ftfd_pkg.sv
rtl/ftfd_buf.sv
rtl/float_tail_frame_deframer_top.sv
dv/float_tail_frame_deframer_top_tb.sv
